[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define HVD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// next-cycle implication
`define HVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define HVD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define HVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// hvd_pkg
// Types, fixed-point constants and the arctangent table of the haversine core.
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int unsigned CORDIC_STEPS = 30;
    localparam int unsigned SQRT_STEPS   = 32;
    localparam int unsigned LANES        = 4;
    localparam int unsigned ANG_W        = 35;
    localparam int unsigned TRIG_W       = 34;
    localparam int unsigned FRAC_W       = 32;
    // 3 input stages, 31 rotation, 4 product/sum, 33 root, 31 vectoring, 2 scale
    localparam int unsigned DEPTH        = 104;

    typedef logic signed [ANG_W-1:0]  t_ang;   // Q3.29 radians
    typedef logic signed [TRIG_W-1:0] t_trig;  // Q2.30 with headroom
    typedef logic signed [FRAC_W-1:0] t_frac;  // Q2.30
    typedef logic signed [32:0]       t_deg;   // degrees * 1e7
    typedef logic [63:0]              t_sq;    // root working word

    localparam t_ang        PI_Q29          = 35'sd1686629713;
    localparam t_ang        HALF_PI_Q29     = 35'sd843314857;
    localparam t_trig       CORDIC_START    = 34'sd652032874;
    localparam logic [31:0] DEG7_TO_RAD     = 32'd4024455254;
    localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
    localparam logic [23:0] RADIUS_RESET    = 24'd6378137;
    localparam logic [30:0] RADIUS_CM_RESET = 31'd637813700;

    function automatic t_ang atan_q29(input logic [4:0] idx);
        t_ang v;
        case (idx)
            5'd0:    v = 35'sd421657428;
            5'd1:    v = 35'sd248918915;
            5'd2:    v = 35'sd131521918;
            5'd3:    v = 35'sd66762579;
            5'd4:    v = 35'sd33510843;
            5'd5:    v = 35'sd16771758;
            5'd6:    v = 35'sd8387925;
            5'd7:    v = 35'sd4194219;
            5'd8:    v = 35'sd2097141;
            5'd9:    v = 35'sd1048575;
            5'd10:   v = 35'sd524288;
            5'd11:   v = 35'sd262144;
            5'd12:   v = 35'sd131072;
            5'd13:   v = 35'sd65536;
            5'd14:   v = 35'sd32768;
            5'd15:   v = 35'sd16384;
            5'd16:   v = 35'sd8192;
            5'd17:   v = 35'sd4096;
            5'd18:   v = 35'sd2048;
            5'd19:   v = 35'sd1024;
            5'd20:   v = 35'sd512;
            5'd21:   v = 35'sd256;
            5'd22:   v = 35'sd128;
            5'd23:   v = 35'sd64;
            5'd24:   v = 35'sd32;
            5'd25:   v = 35'sd16;
            5'd26:   v = 35'sd8;
            5'd27:   v = 35'sd4;
            5'd28:   v = 35'sd2;
            5'd29:   v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/haversine_distance.sv]
// ----------------------------------------------------------------------------
// haversine_distance
// Fully pipelined great-circle distance between two lat/lon points, in cm.
// ----------------------------------------------------------------------------
// Usage
//  - Input channel: i_valid / o_stall with the two points in 1e-7 degree.
//    An item is taken at an edge where i_valid is high and o_stall is low.
//  - Output channel: o_valid / i_stall with o_distance_cm. The result is
//    taken at an edge where o_valid is high and i_stall is low.
//  - Throughput: one item per cycle while the output is not held. The pipe
//    has 104 register stages; o_valid shows the result from the last one.
//    Depth is set by the 30-step rotation CORDIC, the 32-step root and the
//    30-step vectoring CORDIC, each step a pipeline stage.
//  - Stall: the whole pipe advances together. While the output item waits
//    (o_valid and i_stall), every stage holds and o_stall is high.
//  - Config: i_cfg_valid / o_cfg_ready loads the earth radius in metres;
//    ready is always high. Write only while the pipe is empty.
//  - Reset (synchronous, i_rst_n low): all valid bits clear, radius returns
//    to 6378137 m. Payload registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module haversine_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [32:0]        o_distance_cm,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [23:0]        i_cfg_data
);
    import hvd_pkg::*;

    // stage positions in the valid chain
    localparam int unsigned P_ROT0 = 3;
    localparam int unsigned P_A    = P_ROT0 + CORDIC_STEPS + 4;
    localparam int unsigned P_SQ0  = P_A + 1;
    localparam int unsigned P_SQN  = P_SQ0 + SQRT_STEPS;

    logic             w_adv;
    logic [DEPTH-1:0] r_vld;
    logic [30:0]      r_radius_cm;
    logic [30:0]      n_radius_cm;

    // whole pipe moves unless the finished item is held
    assign w_adv       = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall     = !w_adv;
    assign o_valid     = r_vld[DEPTH-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // radius held in centimetres: x100 = x64 + x32 + x4
    assign n_radius_cm = ({7'b0, i_cfg_data} << 6) + ({7'b0, i_cfg_data} << 5)
                       + ({7'b0, i_cfg_data} << 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_cm <= RADIUS_CM_RESET;
        end else if (i_cfg_valid) begin
            r_radius_cm <= n_radius_cm;
        end
    end

    // ---------------- stage 1: angles and exact differences ----------------
    // lanes: 0 lat_a, 1 lat_b, 2 dlat (half angle), 3 dlon (half angle)
    t_deg r1_deg [LANES];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_deg[0] <= 33'(i_lat_a);
            r1_deg[1] <= 33'(i_lat_b);
            r1_deg[2] <= 33'(i_lat_b) - 33'(i_lat_a);
            r1_deg[3] <= 33'(i_lon_b) - 33'(i_lon_a);
        end
    end

    // ---------------- stages 2-3: degrees*1e7 to Q3.29 radians --------------
    logic [63:0] r2_prod [LANES];
    logic        r2_neg  [LANES];
    t_ang        r3_t    [LANES];

    // rotation CORDIC pipe, index 0 holds the reflected start
    t_trig r_cx [CORDIC_STEPS+1][LANES];
    t_trig r_cy [CORDIC_STEPS+1][LANES];
    t_ang  r_cz [CORDIC_STEPS+1][LANES];
    logic  r_cf [CORDIC_STEPS+1][LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam int unsigned SH = (l < 2) ? 32 : 33;
        logic [32:0] w_mag;
        logic [63:0] w_prod;
        logic [63:0] w_sum;
        logic [31:0] w_p;
        t_ang        w_t;
        t_ang        n_z;
        logic        n_f;

        assign w_mag  = r1_deg[l][32] ? 33'(-r1_deg[l]) : 33'(r1_deg[l]);
        assign w_prod = {31'b0, w_mag} * {32'b0, DEG7_TO_RAD};
        assign w_sum  = r2_prod[l] + (64'd1 << (SH - 1));
        assign w_p    = 32'(w_sum >> SH);
        assign w_t    = r2_neg[l] ? -t_ang'({3'b0, w_p}) : t_ang'({3'b0, w_p});

        // fold angles beyond +-pi/2 back; cosine changes sign
        always_comb begin
            n_z = r3_t[l];
            n_f = 1'b0;
            if (r3_t[l] > HALF_PI_Q29) begin
                n_z = PI_Q29 - r3_t[l];
                n_f = 1'b1;
            end else if (r3_t[l] < -HALF_PI_Q29) begin
                n_z = -PI_Q29 - r3_t[l];
                n_f = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r2_prod[l]  <= w_prod;
                r2_neg[l]   <= r1_deg[l][32];
                r3_t[l]     <= w_t;
                r_cx[0][l]  <= CORDIC_START;
                r_cy[0][l]  <= '0;
                r_cz[0][l]  <= n_z;
                r_cf[0][l]  <= n_f;
            end
        end

        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
            t_trig w_dx;
            t_trig w_dy;
            t_trig n_x;
            t_trig n_y;
            t_ang  n_zk;

            assign w_dx = r_cy[k][l] >>> k;
            assign w_dy = r_cx[k][l] >>> k;

            always_comb begin
                if (!r_cz[k][l][ANG_W-1]) begin
                    n_x  = r_cx[k][l] - w_dx;
                    n_y  = r_cy[k][l] + w_dy;
                    n_zk = r_cz[k][l] - atan_q29(5'(k));
                end else begin
                    n_x  = r_cx[k][l] + w_dx;
                    n_y  = r_cy[k][l] - w_dy;
                    n_zk = r_cz[k][l] + atan_q29(5'(k));
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_cx[k+1][l] <= n_x;
                    r_cy[k+1][l] <= n_y;
                    r_cz[k+1][l] <= n_zk;
                    r_cf[k+1][l] <= r_cf[k][l];
                end
            end
        end
    end

    // ---------------- products and the haversine term a ----------------
    t_frac       r5_c1, r5_c2, r5_sh, r5_so;
    t_frac       r6_cc, r6_sh2, r6_so2;
    t_frac       r7_p, r7_sh2;
    logic [30:0] r8_a;
    logic [63:0] w_cc64, w_sh64, w_so64, w_p64;
    logic [32:0] w_a;
    logic [30:0] n_a;

    assign w_cc64 = 64'(r5_c1) * 64'(r5_c2);
    assign w_sh64 = 64'(r5_sh) * 64'(r5_sh);
    assign w_so64 = 64'(r5_so) * 64'(r5_so);
    assign w_p64  = 64'(r6_cc) * 64'(r6_so2);
    assign w_a    = 33'(r7_sh2) + 33'(r7_p);

    // clamp a to [0, 1]
    always_comb begin
        if (w_a[32]) begin
            n_a = '0;
        end else if (w_a > {2'b0, ONE_Q30}) begin
            n_a = ONE_Q30;
        end else begin
            n_a = w_a[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_c1  <= r_cf[CORDIC_STEPS][0] ? 32'(-r_cx[CORDIC_STEPS][0])
                                            : 32'(r_cx[CORDIC_STEPS][0]);
            r5_c2  <= r_cf[CORDIC_STEPS][1] ? 32'(-r_cx[CORDIC_STEPS][1])
                                            : 32'(r_cx[CORDIC_STEPS][1]);
            r5_sh  <= 32'(r_cy[CORDIC_STEPS][2]);
            r5_so  <= 32'(r_cy[CORDIC_STEPS][3]);
            // floor shift by 30: upper slice of the signed product
            r6_cc  <= w_cc64[61:30];
            r6_sh2 <= w_sh64[61:30];
            r6_so2 <= w_so64[61:30];
            r7_p   <= w_p64[61:30];
            r7_sh2 <= r6_sh2;
            r8_a   <= n_a;
        end
    end

    // ---------------- square roots of a and 1-a, one bit per stage ----------
    // lane 0: sqrt(a), lane 1: sqrt(1-a)
    t_sq r_sv [SQRT_STEPS+1][2];
    t_sq r_sr [SQRT_STEPS+1][2];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sv[0][0] <= {3'b0, r8_a, 30'b0};
            r_sv[0][1] <= {3'b0, ONE_Q30 - r8_a, 30'b0};
            r_sr[0][0] <= '0;
            r_sr[0][1] <= '0;
        end
    end

    for (genvar q = 0; q < 2; q++) begin : g_sq
        for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_bit
            localparam t_sq BIT = t_sq'(1) << (62 - 2 * j);
            t_sq w_t;
            t_sq n_v;
            t_sq n_r;

            assign w_t = r_sr[j][q] + BIT;

            always_comb begin
                if (r_sv[j][q] >= w_t) begin
                    n_v = r_sv[j][q] - w_t;
                    n_r = (r_sr[j][q] >> 1) + BIT;
                end else begin
                    n_v = r_sv[j][q];
                    n_r = r_sr[j][q] >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_sv[j+1][q] <= n_v;
                    r_sr[j+1][q] <= n_r;
                end
            end
        end
    end

    // ---------------- vectoring CORDIC: atan2(sqrt(a), sqrt(1-a)) -----------
    t_trig r_ax [CORDIC_STEPS+1];
    t_trig r_ay [CORDIC_STEPS+1];
    t_ang  r_az [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ax[0] <= {3'b0, r_sr[SQRT_STEPS][1][30:0]};
            r_ay[0] <= {3'b0, r_sr[SQRT_STEPS][0][30:0]};
            r_az[0] <= '0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        t_trig w_dx;
        t_trig w_dy;
        t_trig n_x;
        t_trig n_y;
        t_ang  n_z;

        assign w_dx = r_ay[k] >>> k;
        assign w_dy = r_ax[k] >>> k;

        always_comb begin
            if (!r_ay[k][TRIG_W-1]) begin
                n_x = r_ax[k] + w_dx;
                n_y = r_ay[k] - w_dy;
                n_z = r_az[k] + atan_q29(5'(k));
            end else begin
                n_x = r_ax[k] - w_dx;
                n_y = r_ay[k] + w_dy;
                n_z = r_az[k] - atan_q29(5'(k));
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ax[k+1] <= n_x;
                r_ay[k+1] <= n_y;
                r_az[k+1] <= n_z;
            end
        end
    end

    // ---------------- scale by radius, round to centimetres ----------------
    logic [30:0] w_ang;
    logic [61:0] w_m;
    logic [61:0] r_m;
    logic [62:0] w_d;
    logic [32:0] r_dist;

    // negative residue clamps to zero; central angle is twice the half angle
    assign w_ang = r_az[CORDIC_STEPS][ANG_W-1] ? 31'd0
                                               : {r_az[CORDIC_STEPS][29:0], 1'b0};
    assign w_m   = {31'b0, r_radius_cm} * {31'b0, w_ang};
    assign w_d   = {1'b0, r_m} + (63'd1 << 28);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m    <= w_m;
            r_dist <= w_d[61:29];
        end
    end

    assign o_distance_cm = r_dist;

    // ---------------- checks ----------------
    logic w_root_ok;

    assign w_root_ok = (r_sr[SQRT_STEPS][0] <= 64'(ONE_Q30))
                    && (r_sr[SQRT_STEPS][1] <= 64'(ONE_Q30));

    `HVD_ASSERT_NEXT(a_take_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])
    `HVD_ASSERT_NEXT(a_hold_freezes, i_clk, i_rst_n, o_valid && i_stall, $stable(r_vld))
    `HVD_ASSERT_IMPL(a_a_in_range, i_clk, i_rst_n, r_vld[P_A], r8_a <= ONE_Q30)
    `HVD_ASSERT_IMPL(a_root_range, i_clk, i_rst_n, r_vld[P_SQN], w_root_ok)

endmodule
